[design/fl32_pkg.sv]
// ----------------------------------------------------------------------------
// fl32_pkg
// shared constants and the one's-complement adder for the fletcher-32 block
// ----------------------------------------------------------------------------
package fl32_pkg;

	localparam int unsigned SUM_W    = 16;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned CSUM_W   = 2 * SUM_W;

	typedef logic [SUM_W-1:0]  sum_t;
	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [CSUM_W-1:0] csum_t;

	// running sums restart at all ones
	localparam sum_t SUM_INIT = 16'hffff;

	// 16-bit add with the carry folded back into bit 0
	function automatic sum_t oc_add(input sum_t a, input sum_t b);
		logic [SUM_W:0] s;
		logic [SUM_W:0] f;
		s = {1'b0, a} + {1'b0, b};
		f = {1'b0, s[SUM_W-1:0]} + {{SUM_W{1'b0}}, s[SUM_W]};
		return f[SUM_W-1:0];
	endfunction

endpackage

[design/fletcher32_byte_stream_checksum.sv]
// ----------------------------------------------------------------------------
// fletcher32_byte_stream_checksum
// fletcher-32 over a byte stream, bytes paired little-endian into words
// ----------------------------------------------------------------------------
// a last byte passes the input register, then its checksum is loaded into the result register
// throughput: one byte per cycle; only a stalled checksum transaction holds off input
// the sum update is two chained end-around-carry adds between the input
// register and the state/result registers
// reset (arst_n low): stages empty, sums at 0xffff, next byte taken as a low byte
module fletcher32_byte_stream_checksum (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  fl32_pkg::byte_t       data_byte,
	input  logic                  last_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output fl32_pkg::csum_t       checksum
);

	// input register stage
	logic            valid_s1;
	fl32_pkg::byte_t data_s1;
	logic            last_s1;

	// running message state
	fl32_pkg::sum_t  first_sum_q;
	fl32_pkg::sum_t  second_sum_q;
	logic            high_phase_q;

	// result register
	logic            out_valid_q;
	fl32_pkg::csum_t checksum_q;

	logic            out_free;
	logic            advance_s1;
	logic            in_accept;
	fl32_pkg::sum_t  fs_addend;
	fl32_pkg::sum_t  fs_next;
	fl32_pkg::sum_t  ss_next;

	// the result slot is free when empty or being taken this cycle
	assign out_free   = !out_valid_q || out_ready;
	// a non-last byte only touches the sums, so it never waits on the output
	assign advance_s1 = valid_s1 && (!last_s1 || out_free);
	assign in_ready   = !valid_s1 || advance_s1;
	assign in_accept  = in_valid && in_ready;

	// low byte adds as is, high byte adds shifted into the upper half
	always_comb begin
		if (high_phase_q) begin
			fs_addend = {data_s1, {fl32_pkg::BYTE_W{1'b0}}};
		end else begin
			fs_addend = {{fl32_pkg::BYTE_W{1'b0}}, data_s1};
		end
		fs_next = fl32_pkg::oc_add(first_sum_q, fs_addend);
		// second sum takes the new first sum after a high byte, or on a last
		// low byte (same as padding with a zero byte)
		if (high_phase_q || last_s1) begin
			ss_next = fl32_pkg::oc_add(second_sum_q, fs_next);
		end else begin
			ss_next = second_sum_q;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// sum state; a last byte returns everything to the start of a message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_sum_q  <= fl32_pkg::SUM_INIT;
			second_sum_q <= fl32_pkg::SUM_INIT;
			high_phase_q <= 1'b0;
		end else if (advance_s1) begin
			if (last_s1) begin
				first_sum_q  <= fl32_pkg::SUM_INIT;
				second_sum_q <= fl32_pkg::SUM_INIT;
				high_phase_q <= 1'b0;
			end else begin
				first_sum_q  <= fs_next;
				second_sum_q <= ss_next;
				high_phase_q <= !high_phase_q;
			end
		end
	end

	// result register: loaded by a last byte, held until the transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && last_s1) begin
			checksum_q <= {ss_next, fs_next};
		end
	end

	assign out_valid = out_valid_q;
	assign checksum  = checksum_q;

endmodule

[design/fl32_checker.sv]
// ----------------------------------------------------------------------------
// fl32_checker
// port-level checks for the fletcher-32 block
// ----------------------------------------------------------------------------
module fl32_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input fl32_pkg::byte_t       data_byte,
	input logic                  last_byte,
	input logic                  out_valid,
	input logic                  out_ready,
	input fl32_pkg::csum_t       checksum
);

	// a stalled checksum stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(checksum))
		else $error("checksum changed while stalled");

	// end-around carry sums are never zero
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (checksum[15:0] != 16'h0) && (checksum[31:16] != 16'h0))
		else $error("checksum half is zero");

	// input is only held off by a waiting checksum
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

	// a byte held off stays offered until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(data_byte) && $stable(last_byte))
		else $error("input transaction dropped or changed while stalled");

endmodule

bind fletcher32_byte_stream_checksum fl32_checker u_fl32_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.data_byte (data_byte),
	.last_byte (last_byte),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.checksum  (checksum)
);

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// byte messages of many lengths through the fletcher-32 block, each returned
// checksum compared against a local model of the two running sums
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// generous run limit, far above the slowest legal run
	localparam int unsigned CYCLE_LIMIT     = 200000;
	// length of the long receiver hold-off, enough to fill the block and stall input
	localparam int unsigned HOLD_OFF_CYCLES = 300;
	// settle time after the last checksum
	localparam int unsigned DRAIN_CYCLES    = 8;
	// bytes sent in each random phase
	localparam int unsigned PHASE_BYTES     = 220;

	// block ports, all inputs known from time zero
	logic            clk       = 1'b0;
	logic            arst_n    = 1'b0;
	logic            in_valid  = 1'b0;
	logic            in_ready;
	fl32_pkg::byte_t data_byte = '0;
	logic            last_byte = 1'b0;
	logic            out_valid;
	logic            out_ready = 1'b0;
	fl32_pkg::csum_t checksum;

	// local copy of the running sums and of the byte pairing phase
	fl32_pkg::sum_t  model_sum1 = fl32_pkg::SUM_INIT;
	fl32_pkg::sum_t  model_sum2 = fl32_pkg::SUM_INIT;
	logic            model_high = 1'b0;

	// checksums predicted at input acceptance, oldest first
	fl32_pkg::csum_t pending_checksums[$];

	// idle rates in percent, set per phase by the test tasks
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;

	// hold-off request from a test task, served by the receiver process
	int unsigned hold_off_requests = 0;
	int unsigned hold_off_served   = 0;
	int unsigned hold_off_left     = 0;

	// run statistics
	int unsigned bytes_sent        = 0;
	int unsigned messages_sent     = 0;
	int unsigned checksums_checked = 0;
	int unsigned mismatches        = 0;
	int unsigned cycle_count       = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	fletcher32_byte_stream_checksum i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.checksum  (checksum)
	);

	// ------------------------------------------------------------------------
	// checksum model
	// ------------------------------------------------------------------------

	// 16-bit one's-complement add: the carry out wraps into bit 0
	function automatic fl32_pkg::sum_t ones_add(fl32_pkg::sum_t a, fl32_pkg::sum_t b);
		logic [fl32_pkg::SUM_W:0] total;
		total = {1'b0, a} + {1'b0, b};
		return total[fl32_pkg::SUM_W-1:0] + fl32_pkg::sum_t'(total[fl32_pkg::SUM_W]);
	endfunction

	// advance the model by one accepted byte, queue the checksum on a last byte
	function automatic void model_accept(fl32_pkg::byte_t value, logic is_last);
		if (model_high) begin
			// high half of a word, then the word is folded into the second sum
			model_sum1 = ones_add(model_sum1, {value, 8'h00});
			model_sum2 = ones_add(model_sum2, model_sum1);
		end else begin
			model_sum1 = ones_add(model_sum1, {8'h00, value});
			// odd length: the missing high byte counts as zero, word still folds
			if (is_last)
				model_sum2 = ones_add(model_sum2, model_sum1);
		end
		model_high = !model_high;
		if (is_last) begin
			pending_checksums.push_back({model_sum2, model_sum1});
			model_sum1 = fl32_pkg::SUM_INIT;
			model_sum2 = fl32_pkg::SUM_INIT;
			model_high = 1'b0;
		end
	endfunction

	// ------------------------------------------------------------------------
	// sender side
	// ------------------------------------------------------------------------

	// one byte transaction; called right after a rising edge, returns right
	// after the edge at which the byte was accepted
	task automatic send_byte(fl32_pkg::byte_t value, logic is_last);
		// random idle cycles ahead of the transaction, never while valid is up
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= value;
		last_byte <= is_last;
		do
			@(posedge clk);
		while (!in_ready);
		model_accept(value, is_last);
		bytes_sent++;
		if (is_last)
			messages_sent++;
	endtask

	// random byte with the two extremes weighted up
	function automatic fl32_pkg::byte_t pick_byte();
		unique case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hff;
			default: return fl32_pkg::byte_t'($urandom_range(255));
		endcase
	endfunction

	// whole message of random bytes, last mark on the final one
	task automatic send_message(int unsigned len);
		for (int unsigned k = 0; k < len; k++)
			send_byte(pick_byte(), k == len - 1);
	endtask

	// ------------------------------------------------------------------------
	// receiver side
	// ------------------------------------------------------------------------

	// out_ready: long hold-off when requested, otherwise random idling
	always @(posedge clk) begin
		if (hold_off_requests != hold_off_served) begin
			hold_off_served = hold_off_requests;
			hold_off_left   = HOLD_OFF_CYCLES;
		end
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_off_left != 0) begin
			out_ready <= 1'b0;
			hold_off_left--;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// every checksum transaction is matched against the oldest prediction
	always @(posedge clk) begin
		fl32_pkg::csum_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_checksums.size() == 0) begin
				mismatches++;
				$display("%0t ns: unexpected checksum, expected none, actual %08h",
					$time, checksum);
			end else begin
				want = pending_checksums.pop_front();
				checksums_checked++;
				if (checksum !== want) begin
					mismatches++;
					$display("%0t ns: checksum mismatch, expected %08h, actual %08h",
						$time, want, checksum);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// extremes, both pairing phases at the last byte, carry wrap-around
	task automatic test_directed();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		// single-byte messages, smallest and largest byte
		send_byte(8'h00, 1'b1);
		send_byte(8'hff, 1'b1);
		// two-byte messages, last byte in the high half
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b1);
		// three bytes, last byte in the low half with an implied zero high byte
		send_byte(8'h12, 1'b0);
		send_byte(8'h34, 1'b0);
		send_byte(8'h56, 1'b1);
		// alternating bit patterns in both halves
		send_byte(8'h55, 1'b0);
		send_byte(8'haa, 1'b0);
		send_byte(8'haa, 1'b0);
		send_byte(8'h55, 1'b1);
		// all-ones bytes as one message, which makes both sums carry around
		for (int unsigned k = 0; k < 8; k++)
			send_byte(8'hff, k == 7);
	endtask

	// random messages, mostly short, some long, under the given idle rates
	task automatic test_random_messages(int unsigned sender_idle, int unsigned receiver_idle);
		int unsigned start_bytes;
		send_idle_pct = sender_idle;
		recv_idle_pct = receiver_idle;
		start_bytes   = bytes_sent;
		while (bytes_sent - start_bytes < PHASE_BYTES) begin
			if ($urandom_range(9) == 0)
				send_message($urandom_range(13, 64));
			else
				send_message($urandom_range(1, 12));
		end
	endtask

	// receiver holds off for a long stretch while short messages keep coming,
	// so checksums back up and the block has to drop in_ready
	task automatic test_backpressure();
		int unsigned start_bytes;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_off_requests++;
		start_bytes = bytes_sent;
		while (bytes_sent - start_bytes < 48)
			send_message($urandom_range(1, 3));
	endtask

	// ------------------------------------------------------------------------
	// run control
	// ------------------------------------------------------------------------

	// watchdog on cycles, ends a hung run
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d checksums still expected",
			cycle_count, pending_checksums.size());
		$display("FAIL");
		$finish;
	end

	initial begin
		// reset held low, then released at a rising edge
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		// sender idles little while the receiver idles a lot, then swapped, then none
		test_random_messages(8, 83);
		test_random_messages(83, 8);
		test_random_messages(0, 0);
		test_backpressure();
		in_valid <= 1'b0;

		// wait for the last checksums, then wait out the settle time for strays
		while (pending_checksums.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d messages in %0d bytes: one-byte, odd and even lengths, idle mixes",
			messages_sent, bytes_sent);
		$display("plus a %0d-cycle receiver hold-off; %0d checksums compared, %0d mismatches",
			HOLD_OFF_CYCLES, checksums_checked, mismatches);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
